@@ design/threefish_256_encrypt_core_defines.svh @@
// Shared assertion macros for the Threefish-256 core checkers.
`ifndef THREEFISH_256_ENCRYPT_CORE_DEFINES_SVH
`define THREEFISH_256_ENCRYPT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define TF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ design/tf256_pkg.sv @@
package tf256_pkg;

  localparam int unsigned Rounds        = 72;
  localparam int unsigned RoundsPerOct  = 8;
  localparam int unsigned NumOctets     = Rounds / RoundsPerOct;
  localparam int unsigned NumSubkeys    = Rounds / 4 + 1;
  localparam int unsigned NumKeyWords   = 4;

  typedef logic [63:0]      word_t;
  typedef logic [3:0][63:0] block_t;

  localparam word_t KeyParity = 64'h1BD1_1BDA_A9FC_1A22;

  // Tweak word selection codes
  localparam logic [1:0] TwLo  = 2'd0;
  localparam logic [1:0] TwHi  = 2'd1;
  localparam logic [1:0] TwMix = 2'd2;

  typedef struct packed {
    block_t w;
    word_t  tw_lo;
    word_t  tw_hi;
  } tf_item_t;

  typedef struct packed {
    block_t     kw;
    logic [1:0] sel_a;
    logic [1:0] sel_b;
  } subkey_t;

  // Rotation amounts by round mod 8, for pair (0,1) and pair (2,3)
  localparam logic [5:0] RotA [RoundsPerOct] = '{6'd14, 6'd52, 6'd23, 6'd5,
                                                  6'd25, 6'd46, 6'd58, 6'd32};
  localparam logic [5:0] RotB [RoundsPerOct] = '{6'd16, 6'd57, 6'd40, 6'd37,
                                                  6'd33, 6'd12, 6'd22, 6'd32};

  function automatic word_t rotl64(word_t v, logic [5:0] r);
    word_t res;
    if (r == 6'd0) begin
      res = v;
    end else begin
      res = (v << r) | (v >> (7'd64 - {1'b0, r}));
    end
    return res;
  endfunction

  function automatic word_t tweak_word(word_t lo, word_t hi, logic [1:0] sel);
    word_t res;
    case (sel)
      TwLo:    res = lo;
      TwHi:    res = hi;
      TwMix:   res = lo ^ hi;
      default: res = '0;
    endcase
    return res;
  endfunction

  // One MIX round on both pairs followed by the word permutation
  function automatic block_t mix_round(block_t w, logic [5:0] ra, logic [5:0] rb);
    block_t res;
    word_t  y0;
    word_t  y1;
    word_t  y2;
    word_t  y3;
    y0 = w[0] + w[1];
    y1 = rotl64(w[1], ra) ^ y0;
    y2 = w[2] + w[3];
    y3 = rotl64(w[3], rb) ^ y2;
    res[0] = y0;
    res[1] = y3;
    res[2] = y2;
    res[3] = y1;
    return res;
  endfunction

endpackage

@@ design/tf256_inject.sv @@
module tf256_inject (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tf256_pkg::tf_item_t item_i,
  input  tf256_pkg::subkey_t  sk_i,
  output logic                valid_o,
  output tf256_pkg::tf_item_t item_o
);
  import tf256_pkg::*;

  tf_item_t item_d, item_q;
  logic     valid_d, valid_q;

  always_comb begin
    item_d      = item_i;
    item_d.w[0] = item_i.w[0] + sk_i.kw[0];
    item_d.w[1] = item_i.w[1] + sk_i.kw[1] + tweak_word(item_i.tw_lo, item_i.tw_hi, sk_i.sel_a);
    item_d.w[2] = item_i.w[2] + sk_i.kw[2] + tweak_word(item_i.tw_lo, item_i.tw_hi, sk_i.sel_b);
    item_d.w[3] = item_i.w[3] + sk_i.kw[3];
    valid_d     = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ design/tf256_octet.sv @@
// Eight rounds with their two subkey injections, one register stage each.
module tf256_octet (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tf256_pkg::tf_item_t item_i,
  input  tf256_pkg::subkey_t  sk_even_i,
  input  tf256_pkg::subkey_t  sk_odd_i,
  output logic                valid_o,
  output tf256_pkg::tf_item_t item_o
);
  import tf256_pkg::*;

  logic     inj_a_valid, inj_b_valid;
  tf_item_t inj_a_item, inj_b_item;

  tf_item_t rnd_src   [RoundsPerOct];
  logic     rnd_src_v [RoundsPerOct];
  tf_item_t rnd_d     [RoundsPerOct];
  logic     rnd_v_d   [RoundsPerOct];
  tf_item_t rnd_q     [RoundsPerOct];
  logic     rnd_v_q   [RoundsPerOct];

  tf256_inject u_inj_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .item_i  (item_i),
    .sk_i    (sk_even_i),
    .valid_o (inj_a_valid),
    .item_o  (inj_a_item)
  );

  tf256_inject u_inj_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (rnd_v_q[RoundsPerOct/2-1]),
    .item_i  (rnd_q[RoundsPerOct/2-1]),
    .sk_i    (sk_odd_i),
    .valid_o (inj_b_valid),
    .item_o  (inj_b_item)
  );

  for (genvar j = 0; j < RoundsPerOct; j++) begin : g_round
    if (j == 0) begin : g_first
      assign rnd_src[j]   = inj_a_item;
      assign rnd_src_v[j] = inj_a_valid;
    end else if (j == RoundsPerOct / 2) begin : g_mid
      assign rnd_src[j]   = inj_b_item;
      assign rnd_src_v[j] = inj_b_valid;
    end else begin : g_chain
      assign rnd_src[j]   = rnd_q[j-1];
      assign rnd_src_v[j] = rnd_v_q[j-1];
    end

    always_comb begin
      rnd_d[j]   = rnd_src[j];
      rnd_d[j].w = mix_round(rnd_src[j].w, RotA[j], RotB[j]);
      rnd_v_d[j] = rnd_src_v[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RoundsPerOct; k++) begin
        rnd_v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < RoundsPerOct; k++) begin
        rnd_v_q[k] <= rnd_v_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RoundsPerOct; k++) begin
        rnd_q[k] <= rnd_d[k];
      end
    end
  end

  assign valid_o = rnd_v_q[RoundsPerOct-1];
  assign item_o  = rnd_q[RoundsPerOct-1];

endmodule

@@ design/tf256_out_fifo.sv @@
// Two-entry result buffer; keeps the pipeline moving while a result waits.
module tf256_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tf256_pkg::block_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output tf256_pkg::block_t data_o
);
  import tf256_pkg::*;

  block_t     mem_q [2];
  logic       wr_ptr_d, wr_ptr_q;
  logic       rd_ptr_d, rd_ptr_q;
  logic [1:0] count_d, count_q;
  logic       pop;

  assign pop = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

@@ design/threefish_256_encrypt_core.sv @@
// Threefish-256 encryption, fully unrolled: 72 round stages and 19 subkey stages.
// Each block passes through every injection and round register, then the output buffer.
// Throughput: one block per cycle while the two-entry output buffer is not full; input stalls when it is full.
// Key registers feed every subkey stage; the user must keep them static across a block's flight (not enforced).
// Reset (rst_ni low, asynchronous) clears all valid bits and the key to zero and empties the buffer.
module threefish_256_encrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] tweak_lo_i,
  input  logic [63:0] tweak_hi_i,
  input  logic [63:0] plain0_i,
  input  logic [63:0] plain1_i,
  input  logic [63:0] plain2_i,
  input  logic [63:0] plain3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher0_o,
  output logic [63:0] cipher1_o,
  output logic [63:0] cipher2_o,
  output logic [63:0] cipher3_o
);
  import tf256_pkg::*;

  word_t      key_q [NumKeyWords];
  logic [4:0][63:0] ks;
  subkey_t    subkey [NumSubkeys];

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  tf_item_t   oct_item  [NumOctets+1];
  logic       oct_valid [NumOctets+1];
  tf_item_t   fin_item;
  logic       fin_valid;
  logic       fifo_full;
  logic       en;
  block_t     out_data;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = key_q[cfg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeyWords; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_wr) begin
      key_q[cfg_idx] <= pwdata;
    end
  end

  // Extended key schedule
  always_comb begin
    ks[4] = KeyParity;
    for (int k = 0; k < NumKeyWords; k++) begin
      ks[k] = key_q[k];
      ks[4] = ks[4] ^ key_q[k];
    end
  end

  for (genvar s = 0; s < NumSubkeys; s++) begin : g_subkey
    assign subkey[s].kw[0] = ks[s % 5];
    assign subkey[s].kw[1] = ks[(s + 1) % 5];
    assign subkey[s].kw[2] = ks[(s + 2) % 5];
    assign subkey[s].kw[3] = ks[(s + 3) % 5] + 64'(s);
    assign subkey[s].sel_a = 2'(s % 3);
    assign subkey[s].sel_b = 2'((s + 1) % 3);
  end

  // Advance the whole pipeline unless the output buffer is full
  assign en         = !fifo_full;
  assign in_ready_o = en;

  assign oct_valid[0]      = in_valid_i;
  assign oct_item[0].tw_lo = tweak_lo_i;
  assign oct_item[0].tw_hi = tweak_hi_i;
  assign oct_item[0].w[0]  = plain0_i;
  assign oct_item[0].w[1]  = plain1_i;
  assign oct_item[0].w[2]  = plain2_i;
  assign oct_item[0].w[3]  = plain3_i;

  for (genvar o = 0; o < NumOctets; o++) begin : g_octet
    tf256_octet u_octet (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (oct_valid[o]),
      .item_i    (oct_item[o]),
      .sk_even_i (subkey[2*o]),
      .sk_odd_i  (subkey[2*o+1]),
      .valid_o   (oct_valid[o+1]),
      .item_o    (oct_item[o+1])
    );
  end

  tf256_inject u_inj_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (oct_valid[NumOctets]),
    .item_i  (oct_item[NumOctets]),
    .sk_i    (subkey[NumSubkeys-1]),
    .valid_o (fin_valid),
    .item_o  (fin_item)
  );

  tf256_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && fin_valid),
    .data_i  (fin_item.w),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign cipher0_o = out_data[0];
  assign cipher1_o = out_data[1];
  assign cipher2_o = out_data[2];
  assign cipher3_o = out_data[3];

endmodule

@@ design/tf256_port_chk.sv @@
`include "threefish_256_encrypt_core_defines.svh"

module tf256_port_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] cipher0_o
);

  // 91 pipeline stages plus two buffer entries
  localparam logic [6:0] MaxInFlight = 7'd93;

  logic [6:0] outstanding_d, outstanding_q;
  logic       in_xact, out_xact;

  assign in_xact  = in_valid_i && in_ready_o;
  assign out_xact = out_valid_o && out_ready_i;

  always_comb begin
    outstanding_d = outstanding_q + {6'd0, in_xact} - {6'd0, out_xact};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  `TF_ASSERT_NOW(a_pready_high, clk_i, rst_ni, 1'b1, pready)
  `TF_ASSERT_NOW(a_out_has_source, clk_i, rst_ni, out_valid_o, outstanding_q != 7'd0)
  `TF_ASSERT_NOW(a_inflight_bound, clk_i, rst_ni, 1'b1, outstanding_q <= MaxInFlight)
  `TF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(cipher0_o))

endmodule

bind threefish_256_encrypt_core tf256_port_chk u_port_chk (.*);
